FILE: src/lav_pkg.sv
// lav_pkg: shared types and constants of the look-at view matrix block.
// Used by lav_front, lav_norm, lav_back and look_at_view_matrix_top.
package lav_pkg;
    localparam int W  = 32;
    localparam int DW = 33;
    localparam int VW = 64;

    typedef logic signed [W-1:0]  t_word;
    typedef logic signed [DW-1:0] t_diff;
    typedef logic signed [VW-1:0] t_wide;

    typedef struct packed {
        t_word [2:0] eye;
        t_diff [2:0] fwd;
        t_word [2:0] up;
    } t_item;

    typedef struct packed {
        logic        done;
        logic        zero;
        t_word [2:0] vec;
    } t_norm_rsp;

    // cross product term order: o0 = a1*b2 - a2*b1, o1 = a2*b0 - a0*b2, o2 = a0*b1 - a1*b0
    function automatic logic [1:0] cross_a(input logic [2:0] k);
        logic [1:0] r;
        begin
            case (k)
                3'd0: r = 2'd1;
                3'd1: r = 2'd2;
                3'd2: r = 2'd2;
                3'd3: r = 2'd0;
                3'd4: r = 2'd0;
                default: r = 2'd1;
            endcase
            return r;
        end
    endfunction

    function automatic logic [1:0] cross_b(input logic [2:0] k);
        logic [1:0] r;
        begin
            case (k)
                3'd0: r = 2'd2;
                3'd1: r = 2'd1;
                3'd2: r = 2'd0;
                3'd3: r = 2'd2;
                3'd4: r = 2'd1;
                default: r = 2'd0;
            endcase
            return r;
        end
    endfunction
endpackage

FILE: src/look_at_view_matrix_top.sv
// Look-at view matrix: four rows (side, up, -forward, homogeneous) per command.
// The back end takes a new command from the queue only after the last row of the one before;
// each normalization runs longer with more scaling shifts; zero-length vectors finish sooner.
// All four normalizations run one after another on the single shared normalizer.
// Two-entry command queue, busy when full; rows on consecutive o_strobe cycles, no stall.
// Synchronous active-low reset empties the queue and idles the sequencer.
module look_at_view_matrix_top
    import lav_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_eye_x,
    input  logic [31:0] i_eye_y,
    input  logic [31:0] i_eye_z,
    input  logic [31:0] i_target_x,
    input  logic [31:0] i_target_y,
    input  logic [31:0] i_target_z,
    input  logic [31:0] i_upvec_x,
    input  logic [31:0] i_upvec_y,
    input  logic [31:0] i_upvec_z,
    output logic        o_strobe,
    output logic [1:0]  o_row_index,
    output logic [31:0] o_elem_0,
    output logic [31:0] o_elem_1,
    output logic [31:0] o_elem_2,
    output logic [31:0] o_elem_3,
    output logic        o_degenerate,
    output logic        o_last_row
);
    t_word [2:0] w_eye;
    t_word [2:0] w_tgt;
    t_word [2:0] w_up;
    t_item       w_item;
    logic        w_valid;
    logic        w_pop;

    assign w_eye = {i_eye_z, i_eye_y, i_eye_x};
    assign w_tgt = {i_target_z, i_target_y, i_target_x};
    assign w_up  = {i_upvec_z, i_upvec_y, i_upvec_x};

    lav_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_eye   (w_eye),
        .i_tgt   (w_tgt),
        .i_up    (w_up),
        .o_item  (w_item),
        .o_valid (w_valid),
        .i_pop   (w_pop)
    );

    lav_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_item),
        .i_valid      (w_valid),
        .o_pop        (w_pop),
        .o_strobe     (o_strobe),
        .o_row_index  (o_row_index),
        .o_elem_0     (o_elem_0),
        .o_elem_1     (o_elem_1),
        .o_elem_2     (o_elem_2),
        .o_elem_3     (o_elem_3),
        .o_degenerate (o_degenerate),
        .o_last_row   (o_last_row)
    );
endmodule

FILE: src/lav_front.sv
// lav_front: accepts commands, forms target - eye, and holds items in a two-entry queue.
// Depends on lav_pkg.
module lav_front
    import lav_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  t_word [2:0] i_eye,
    input  t_word [2:0] i_tgt,
    input  t_word [2:0] i_up,
    output t_item       o_item,
    output logic        o_valid,
    input  logic        i_pop
);
    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_item      w_new;
    logic       w_push;

    always_comb begin
        w_new.eye = i_eye;
        w_new.up  = i_up;
        for (int i = 0; i < 3; i++) begin
            w_new.fwd[i] = $signed({i_tgt[i][W-1], i_tgt[i]}) -
                           $signed({i_eye[i][W-1], i_eye[i]});
        end
    end

    assign o_busy  = (r_cnt == 2'd2);
    assign w_push  = i_start && !o_busy;
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= w_new;
                r_wp      <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (w_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!w_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end
endmodule

FILE: src/lav_norm.sv
// lav_norm: iterative vector normalizer (scale, sum of squares, square root, divide).
// Depends on lav_pkg.
module lav_norm
    import lav_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_wide [2:0] i_vec,
    output t_norm_rsp   o_rsp
);
    localparam int QB = FRAC_BITS + 2;
    localparam int NW = FRAC_BITS + 32;
    localparam int CW = ($clog2(QB) > 5) ? $clog2(QB) : 5;

    localparam logic [2:0] N_IDLE  = 3'd0;
    localparam logic [2:0] N_SCALE = 3'd1;
    localparam logic [2:0] N_SQ    = 3'd2;
    localparam logic [2:0] N_SQRT  = 3'd3;
    localparam logic [2:0] N_DINIT = 3'd4;
    localparam logic [2:0] N_DIV   = 3'd5;

    logic [2:0]    r_state;
    logic [CW-1:0] r_cnt;
    logic [63:0]   r_m    [3];
    logic          r_neg  [3];
    logic [61:0]   r_acc;
    logic [59:0]   r_prod;
    logic [61:0]   r_res;
    logic [61:0]   r_bit;
    logic [31:0]   r_drem [3];
    logic [QB-1:0] r_nlo  [3];
    logic [QB-1:0] r_q    [3];
    logic          r_done;
    logic          r_zero;
    t_word [2:0]   r_out;

    logic          w_any_hi;
    logic          w_all_lo;
    logic [61:0]   w_tst;
    logic [31:0]   w_d;
    logic [NW-1:0] w_n    [3];
    logic [32:0]   w_t    [3];
    logic          w_ge   [3];
    logic [32:0]   w_sub  [3];

    always_comb begin
        w_any_hi = 1'b0;
        w_all_lo = 1'b1;
        for (int i = 0; i < 3; i++) begin
            if (r_m[i][63:30] != '0) w_any_hi = 1'b1;
            if (r_m[i][63:29] != '0) w_all_lo = 1'b0;
        end
        w_tst = r_res + r_bit;
        w_d   = {r_res[30:0], 1'b0};
        for (int i = 0; i < 3; i++) begin
            w_n[i]   = (NW'(r_m[i][29:0]) << (FRAC_BITS + 1)) + NW'(r_res[30:0]);
            w_t[i]   = {r_drem[i], r_nlo[i][QB-1]};
            w_ge[i]  = (w_t[i] >= {1'b0, w_d});
            w_sub[i] = w_t[i] - {1'b0, w_d};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.zero = r_zero;
    assign o_rsp.vec  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                N_IDLE: begin
                    if (i_start) begin
                        for (int i = 0; i < 3; i++) begin
                            r_neg[i] <= i_vec[i][VW-1];
                            r_m[i]   <= i_vec[i][VW-1] ? 64'(-i_vec[i]) : 64'(i_vec[i]);
                        end
                        r_acc <= '0;
                        if (i_vec[0] == '0 && i_vec[1] == '0 && i_vec[2] == '0) begin
                            r_out  <= '0;
                            r_zero <= 1'b1;
                            r_done <= 1'b1;
                        end else begin
                            r_state <= N_SCALE;
                        end
                    end
                end
                N_SCALE: begin
                    if (w_any_hi) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
                    end else if (w_all_lo) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] << 1;
                    end else begin
                        r_cnt   <= '0;
                        r_state <= N_SQ;
                    end
                end
                N_SQ: begin
                    if (r_cnt < CW'(3)) begin
                        r_prod <= r_m[r_cnt[1:0]][29:0] * r_m[r_cnt[1:0]][29:0];
                    end
                    if (r_cnt != '0) begin
                        r_acc <= r_acc + 62'(r_prod);
                    end
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(3)) begin
                        r_res   <= '0;
                        r_bit   <= 62'(1) << 60;
                        r_state <= N_SQRT;
                    end
                end
                N_SQRT: begin
                    if (r_acc >= w_tst) begin
                        r_acc <= r_acc - w_tst;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) r_state <= N_DINIT;
                end
                N_DINIT: begin
                    for (int i = 0; i < 3; i++) begin
                        r_drem[i] <= 32'(w_n[i][NW-1:QB]);
                        r_nlo[i]  <= w_n[i][QB-1:0];
                    end
                    r_cnt   <= CW'(QB - 1);
                    r_state <= N_DIV;
                end
                N_DIV: begin
                    for (int i = 0; i < 3; i++) begin
                        r_drem[i] <= w_ge[i] ? w_sub[i][31:0] : w_t[i][31:0];
                        r_nlo[i]  <= r_nlo[i] << 1;
                        r_q[i]    <= {r_q[i][QB-2:0], w_ge[i]};
                    end
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == '0) begin
                        for (int i = 0; i < 3; i++) begin
                            r_out[i] <= r_neg[i] ? -t_word'({r_q[i][QB-2:0], w_ge[i]})
                                                 :  t_word'({r_q[i][QB-2:0], w_ge[i]});
                        end
                        r_zero  <= 1'b0;
                        r_done  <= 1'b1;
                        r_state <= N_IDLE;
                    end
                end
                default: r_state <= N_IDLE;
            endcase
        end
    end
endmodule

FILE: src/lav_back.sv
// lav_back: sequences normalizations, cross products and translation dots, emits rows.
// Depends on lav_pkg and lav_norm.
module lav_back
    import lav_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_item      i_item,
    input  logic       i_valid,
    output logic       o_pop,
    output logic       o_strobe,
    output logic [1:0] o_row_index,
    output t_word      o_elem_0,
    output t_word      o_elem_1,
    output t_word      o_elem_2,
    output t_word      o_elem_3,
    output logic       o_degenerate,
    output logic       o_last_row
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_NFWD  = 3'd1;
    localparam logic [2:0] S_NUP   = 3'd2;
    localparam logic [2:0] S_CROSS = 3'd3;
    localparam logic [2:0] S_NSIDE = 3'd4;
    localparam logic [2:0] S_NUP2  = 3'd5;
    localparam logic [2:0] S_DOT   = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    localparam logic [31:0] ONE_Q   = 32'(1) << FRAC_BITS;
    localparam logic [65:0] HALF_Q  = 66'(1) << (FRAC_BITS - 1);
    localparam logic [65:0] NEG_LIM = 66'h0_8000_0000;
    localparam logic [65:0] POS_LIM = 66'h0_7FFF_FFFF;

    logic [2:0]  r_state;
    logic [2:0]  r_cnt;
    logic [1:0]  r_row;
    logic        r_second;
    logic        r_degen;
    logic        r_nstart;
    t_wide [2:0] r_nvec;
    t_word       r_eye  [3];
    t_word       r_fwd  [3];
    t_word       r_upv  [3];
    t_word       r_rows [3][3];
    t_word       r_ca   [3];
    t_word       r_cb   [3];
    t_wide       r_cr   [3];
    t_wide       r_prod;
    logic signed [65:0] r_acc;
    t_word       r_trans [3];
    logic        r_strobe;
    logic [1:0]  r_oidx;
    t_word       r_oe    [4];
    logic        r_olast;
    logic        r_odeg;

    t_norm_rsp   w_rsp;
    logic [2:0]  w_j;
    logic [1:0]  w_ci;
    logic [65:0] w_mag;
    logic [65:0] w_qr;
    t_word       w_trans;

    lav_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_nstart),
        .i_vec   (r_nvec),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        w_j   = r_cnt - 3'd1;
        w_ci  = w_j[2:1];
        w_mag = r_acc[65] ? 66'(-r_acc) : 66'(r_acc);
        w_qr  = (w_mag + HALF_Q) >> FRAC_BITS;
        if (!r_acc[65] && r_acc != '0) begin
            w_trans = (w_qr > NEG_LIM) ? t_word'(-NEG_LIM) : t_word'(-w_qr);
        end else begin
            w_trans = (w_qr > POS_LIM) ? t_word'(POS_LIM) : t_word'(w_qr);
        end
    end

    assign o_pop        = (r_state == S_IDLE) && i_valid;
    assign o_strobe     = r_strobe;
    assign o_row_index  = r_oidx;
    assign o_elem_0     = r_oe[0];
    assign o_elem_1     = r_oe[1];
    assign o_elem_2     = r_oe[2];
    assign o_elem_3     = r_oe[3];
    assign o_degenerate = r_odeg;
    assign o_last_row   = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_nstart <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_nstart <= 1'b0;
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        for (int i = 0; i < 3; i++) begin
                            r_eye[i]  <= i_item.eye[i];
                            r_upv[i]  <= i_item.up[i];
                            r_nvec[i] <= VW'($signed(i_item.fwd[i]));
                        end
                        r_degen  <= 1'b0;
                        r_nstart <= 1'b1;
                        r_state  <= S_NFWD;
                    end
                end
                S_NFWD: begin
                    if (w_rsp.done) begin
                        for (int i = 0; i < 3; i++) begin
                            r_fwd[i]     <= w_rsp.vec[i];
                            r_rows[2][i] <= -w_rsp.vec[i];
                            r_nvec[i]    <= VW'($signed(r_upv[i]));
                        end
                        r_degen  <= r_degen | w_rsp.zero;
                        r_nstart <= 1'b1;
                        r_state  <= S_NUP;
                    end
                end
                S_NUP: begin
                    if (w_rsp.done) begin
                        for (int i = 0; i < 3; i++) begin
                            r_ca[i] <= r_fwd[i];
                            r_cb[i] <= w_rsp.vec[i];
                        end
                        r_degen  <= r_degen | w_rsp.zero;
                        r_second <= 1'b0;
                        r_cnt    <= '0;
                        r_state  <= S_CROSS;
                    end
                end
                S_CROSS: begin
                    if (r_cnt < 3'd6) begin
                        r_prod <= r_ca[cross_a(r_cnt)] * r_cb[cross_b(r_cnt)];
                    end
                    if (r_cnt != 3'd0 && r_cnt != 3'd7) begin
                        r_cr[w_ci] <= w_j[0] ? r_cr[w_ci] - r_prod : r_prod;
                    end
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd7) begin
                        for (int i = 0; i < 3; i++) r_nvec[i] <= r_cr[i];
                        r_nstart <= 1'b1;
                        r_state  <= r_second ? S_NUP2 : S_NSIDE;
                    end
                end
                S_NSIDE: begin
                    if (w_rsp.done) begin
                        for (int i = 0; i < 3; i++) begin
                            r_rows[0][i] <= w_rsp.vec[i];
                            r_ca[i]      <= w_rsp.vec[i];
                            r_cb[i]      <= r_fwd[i];
                        end
                        r_degen  <= r_degen | w_rsp.zero;
                        r_second <= 1'b1;
                        r_cnt    <= '0;
                        r_state  <= S_CROSS;
                    end
                end
                S_NUP2: begin
                    if (w_rsp.done) begin
                        for (int i = 0; i < 3; i++) r_rows[1][i] <= w_rsp.vec[i];
                        r_degen <= r_degen | w_rsp.zero;
                        r_row   <= 2'd0;
                        r_cnt   <= '0;
                        r_state <= S_DOT;
                    end
                end
                S_DOT: begin
                    if (r_cnt < 3'd3) begin
                        r_prod <= r_rows[r_row][r_cnt[1:0]] * r_eye[r_cnt[1:0]];
                    end
                    if (r_cnt == 3'd0) begin
                        r_acc <= '0;
                    end else if (r_cnt < 3'd4) begin
                        r_acc <= r_acc + {{2{r_prod[VW-1]}}, r_prod};
                    end
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd4) begin
                        r_trans[r_row] <= w_trans;
                        r_cnt          <= '0;
                        if (r_row == 2'd2) begin
                            r_row   <= 2'd0;
                            r_state <= S_EMIT;
                        end else begin
                            r_row <= r_row + 2'd1;
                        end
                    end
                end
                S_EMIT: begin
                    r_strobe <= 1'b1;
                    r_oidx   <= r_row;
                    r_odeg   <= r_degen;
                    r_olast  <= (r_row == 2'd3);
                    if (r_row == 2'd3) begin
                        r_oe[0] <= '0;
                        r_oe[1] <= '0;
                        r_oe[2] <= '0;
                        r_oe[3] <= t_word'(ONE_Q);
                        r_state <= S_IDLE;
                    end else begin
                        for (int i = 0; i < 3; i++) r_oe[i] <= r_rows[r_row][i];
                        r_oe[3] <= r_trans[r_row];
                    end
                    r_row <= r_row + 2'd1;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: tb/tb_look_at_view_matrix_top.sv
// Testbench for look_at_view_matrix_top: random and directed look-at commands.
// A scoreboard class predicts the four view matrix rows; depends on lav_pkg only for the DUT.
module tb_look_at_view_matrix_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 16;

    typedef struct packed {
        logic [1:0]  row;
        logic [31:0] e0, e1, e2, e3;
        logic        degen, last;
    } t_row;

    class view_scoreboard;
        t_row pending[$];
        int   errors = 0;

        function automatic logic [63:0] mag(longint v);
            return v < 0 ? -v : v;
        endfunction

        function automatic logic [63:0] isqrt(logic [63:0] s);
            logic [63:0] res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > s) b = b >> 2;
            while (b != 0) begin
                if (s >= res + b) begin
                    s = s - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function automatic bit unit_vec(longint v[3], output longint o[3]);
            logic [63:0] m[3], top, s, r, q;
            for (int i = 0; i < 3; i++) m[i] = mag(v[i]);
            top = m[0];
            if (m[1] > top) top = m[1];
            if (m[2] > top) top = m[2];
            if (top == 0) begin
                o[0] = 0; o[1] = 0; o[2] = 0;
                return 1;
            end
            while (top >= (64'd1 << 30)) begin
                top = top >> 1;
                for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
            end
            while (top < (64'd1 << 29)) begin
                top = top << 1;
                for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
            end
            s = m[0]*m[0] + m[1]*m[1] + m[2]*m[2];
            r = isqrt(s);
            for (int i = 0; i < 3; i++) begin
                q = ((m[i] << (FB + 1)) + r) / (2 * r);
                o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
            end
            return 0;
        endfunction

        function automatic void cross_prod(longint a[3], longint b[3], output longint o[3]);
            o[0] = a[1]*b[2] - a[2]*b[1];
            o[1] = a[2]*b[0] - a[0]*b[2];
            o[2] = a[0]*b[1] - a[1]*b[0];
        endfunction

        function automatic logic [31:0] translation(longint r[3], longint e[3]);
            longint sum;
            logic [63:0] q;
            sum = r[0]*e[0] + r[1]*e[1] + r[2]*e[2];
            q = (mag(sum) + (64'd1 << (FB - 1))) >> FB;
            if (sum > 0) begin
                if (q > 64'h80000000) q = 64'h80000000;
                return 32'(-longint'(q));
            end
            if (q > 64'h7FFFFFFF) q = 64'h7FFFFFFF;
            return q[31:0];
        endfunction

        function void note_command(logic [31:0] in[9]);
            longint eye[3], t[3], f[3], u[3], sd[3], u2[3], nf[3];
            bit dg;
            t_row x;
            for (int i = 0; i < 3; i++) begin
                eye[i] = longint'($signed(in[i]));
                t[i] = longint'($signed(in[3+i])) - eye[i];
            end
            dg = unit_vec(t, f);
            for (int i = 0; i < 3; i++) t[i] = longint'($signed(in[6+i]));
            dg |= unit_vec(t, u);
            cross_prod(f, u, t);
            dg |= unit_vec(t, sd);
            cross_prod(sd, f, t);
            dg |= unit_vec(t, u2);
            for (int i = 0; i < 3; i++) nf[i] = -f[i];
            x = '{2'd0, 32'(sd[0]), 32'(sd[1]), 32'(sd[2]), translation(sd, eye), dg, 1'b0};
            pending.push_back(x);
            x = '{2'd1, 32'(u2[0]), 32'(u2[1]), 32'(u2[2]), translation(u2, eye), dg, 1'b0};
            pending.push_back(x);
            x = '{2'd2, 32'(nf[0]), 32'(nf[1]), 32'(nf[2]), translation(nf, eye), dg, 1'b0};
            pending.push_back(x);
            x = '{2'd3, 32'd0, 32'd0, 32'd0, 32'd1 << FB, dg, 1'b1};
            pending.push_back(x);
        endfunction

        function void check_row(t_row a);
            t_row e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected row %0d", a.row);
                return;
            end
            e = pending.pop_front();
            if (a != e) begin
                errors++;
                if (errors <= 10)
                    $display("row mismatch exp %0d %h %h %h %h %b %b got %0d %h %h %h %h %b %b",
                        e.row, e.e0, e.e1, e.e2, e.e3, e.degen, e.last,
                        a.row, a.e0, a.e1, a.e2, a.e3, a.degen, a.last);
            end
        endfunction
    endclass

    logic        i_clk = 0, i_rst_n = 0, start = 0;
    logic        busy, o_strobe, o_degenerate, o_last_row;
    logic [31:0] cmd[9] = '{default: 32'd0};
    logic [1:0]  o_row_index;
    logic [31:0] o_elem_0, o_elem_1, o_elem_2, o_elem_3;
    view_scoreboard sb = new();

    always #5 i_clk = ~i_clk;

    look_at_view_matrix_top #(.FRAC_BITS(FB)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_eye_x(cmd[0]), .i_eye_y(cmd[1]), .i_eye_z(cmd[2]),
        .i_target_x(cmd[3]), .i_target_y(cmd[4]), .i_target_z(cmd[5]),
        .i_upvec_x(cmd[6]), .i_upvec_y(cmd[7]), .i_upvec_z(cmd[8]),
        .o_strobe(o_strobe), .o_row_index(o_row_index),
        .o_elem_0(o_elem_0), .o_elem_1(o_elem_1), .o_elem_2(o_elem_2), .o_elem_3(o_elem_3),
        .o_degenerate(o_degenerate), .o_last_row(o_last_row)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_row('{o_row_index, o_elem_0, o_elem_1, o_elem_2, o_elem_3,
                           o_degenerate, o_last_row});
    end

    // one command transfer; start stays high into the next transfer when no gap is drawn
    task automatic send(logic [31:0] v[9]);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            start <= 0;
            repeat (gap) @(posedge i_clk);
        end
        for (int i = 0; i < 9; i++) cmd[i] <= v[i];
        start <= 1;
        do @(posedge i_clk); while (busy);
        sb.note_command(v);
    endtask

    function automatic logic [31:0] rnd_word(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 20) << FB;
            2: return -($urandom_range(0, 20) << FB);
            3: return $signed(32'($urandom_range(0, 2000))) - 1000;
            default: return $urandom & 32'h00FF_FFFF;
        endcase
    endfunction

    initial begin
        logic [31:0] v[9];
        logic [31:0] ext[4];
        ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // canonical camera
        v = '{0, 0, 32'h0005_0000, 0, 0, 0, 0, 32'h0001_0000, 0};
        send(v);
        // eye equals target
        v = '{32'h0001_0000, 2, 3, 32'h0001_0000, 2, 3, 0, 32'h0001_0000, 0};
        send(v);
        // zero up
        v = '{0, 0, 0, 32'h0001_0000, 0, 0, 0, 0, 0};
        send(v);
        // up parallel to forward
        v = '{0, 0, 0, 0, 32'h0003_0000, 0, 0, 32'hFFFF_0000, 0};
        send(v);
        // extreme corners
        for (int k = 0; k < 16; k++) begin
            for (int i = 0; i < 9; i++) v[i] = ext[(k + i * (k / 4 + 1)) % 4];
            send(v);
        end
        v = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0, 0};
        send(v);
        v = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 32'hFFFF_FFFF};
        send(v);
        for (int n = 0; n < 148; n++) begin
            int mode;
            mode = $urandom_range(0, 4);
            for (int i = 0; i < 9; i++) v[i] = rnd_word($urandom_range(0, 3) == 0 ? $urandom_range(0, 4) : mode);
            if ($urandom_range(0, 15) == 0) for (int i = 0; i < 3; i++) v[3+i] = v[i];
            send(v);
        end
        start <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tb_look_at_view_matrix_top passed");
        else
            $display("tb_look_at_view_matrix_top failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_look_at_view_matrix_top failed");
        $finish;
    end
endmodule
